/* design/i2c_master_bit_sequencer_macros.svh */
// assertion macros for the i2c master bit sequencer
// expects clk and rst_n in the scope of the module that uses them
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// checked on every rising edge once reset is released
`define I2CMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define I2CMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/i2cms_pkg.sv */
// shared types and constants of the i2c master bit sequencer
// no dependencies
package i2cms_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int PT_W            = 16;
  localparam logic [PT_W-1:0] PHASE_TICKS_RST = 16'd100;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ      = 3'd4,
    CMD_MACK      = 3'd5,
    CMD_CHECK_ACK = 3'd6,
    CMD_NACK_WAIT = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_bit;
  } out_item_t;

  typedef struct packed {
    logic scl;
    logic drv;
    logic lvl;
  } line_t;

endpackage

/* design/i2cms_in_reg.sv */
// input register of the i2c master bit sequencer
// depends on i2cms_pkg
module i2cms_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cms_pkg::in_item_t in_item,
  input  logic               adv,
  output logic               item_valid,
  output i2cms_pkg::in_item_t item
);
  import i2cms_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready   = !valid_r || adv;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* design/i2cms_core.sv */
// line sequencer state and per-cycle update of the i2c master bit sequencer
// depends on i2cms_pkg and i2c_master_bit_sequencer_macros.svh
module i2cms_core #(
  parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [i2cms_pkg::PT_W-1:0] phase_ticks,
  input  i2cms_pkg::in_item_t        item,
  input  logic                      adv,
  output i2cms_pkg::out_item_t       res
);
  import i2cms_pkg::*;
  `include "i2c_master_bit_sequencer_macros.svh"

  localparam int LW = (COUNT_WIDTH > PT_W) ? COUNT_WIDTH : PT_W;
  localparam logic [LW-1:0] CMAX = LW'({COUNT_WIDTH{1'b1}});

  logic [2:0]             act_r,  act_nxt;
  logic [5:0]             ph_r,   ph_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [7:0]             sh_r,   sh_nxt;
  logic                   ack_r,  ack_nxt;
  logic [7:0]             rd_r,   rd_nxt;
  line_t                  ln_r,   ln_nxt;
  logic                   done;

  logic [LW-1:0]          pt_ext;
  logic [LW-1:0]          len_w;
  logic [COUNT_WIDTH-1:0] len;
  logic [5:0]             nx;
  logic                   stop_poll;

  function automatic logic [5:0] div3(input logic [5:0] p);
    logic [12:0] m;
    m = {7'd0, p} * 13'd43;
    return m[12:7];
  endfunction

  function automatic logic [5:0] mod3(input logic [5:0] p);
    logic [5:0] q;
    q = div3(p);
    return p - 6'(q * 6'd3);
  endfunction

  function automatic logic [5:0] mod6(input logic [5:0] p);
    logic [5:0] q;
    q = div3(p) >> 1;
    return p - 6'(q * 6'd6);
  endfunction

  function automatic logic [5:0] phase_total(input logic [2:0] c);
    logic [5:0] n;
    case (c)
      CMD_START: n = 6'd4;
      CMD_STOP:  n = 6'd3;
      CMD_WRITE: n = 6'd24;
      CMD_READ:  n = 6'd48;
      CMD_MACK:  n = 6'd4;
      default:   n = 6'd5;
    endcase
    return n;
  endfunction

  function automatic line_t enter_phase(input logic [2:0] c, input logic [5:0] p,
                                        input logic [7:0] s, input line_t cur);
    line_t l;
    logic [5:0] q3;
    logic [2:0] bidx;
    l    = cur;
    q3   = div3(p);
    bidx = 3'd7 - q3[2:0];
    case (c)
      CMD_START: begin
        if (p == 6'd0) begin
          l.drv = 1'b1;
          l.lvl = 1'b1;
        end else if (p == 6'd1) begin
          l.scl = 1'b1;
        end else if (p == 6'd2) begin
          l.lvl = 1'b0;
        end else begin
          l.scl = 1'b0;
        end
      end
      CMD_STOP: begin
        if (p == 6'd0) begin
          l.drv = 1'b1;
          l.lvl = 1'b0;
        end else if (p == 6'd1) begin
          l.scl = 1'b1;
        end else begin
          l.lvl = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (mod3(p) == 6'd0) begin
          l.drv = 1'b1;
          l.lvl = s[bidx];
        end else if (mod3(p) == 6'd1) begin
          l.scl = 1'b1;
        end else begin
          l.scl = 1'b0;
        end
      end
      CMD_READ: begin
        if (p == 6'd0) begin
          l.drv = 1'b0;
          l.lvl = 1'b1;
        end
        if (mod6(p) == 6'd0) begin
          l.scl = 1'b1;
        end else if (mod6(p) == 6'd4) begin
          l.scl = 1'b0;
        end
      end
      CMD_MACK: begin
        if (p == 6'd0) begin
          l.drv = 1'b1;
          l.lvl = 1'b0;
        end else if (p == 6'd1) begin
          l.scl = 1'b1;
        end else if (p == 6'd3) begin
          l.scl = 1'b0;
        end
      end
      default: begin
        if (p == 6'd0) begin
          l.drv = 1'b1;
          l.lvl = 1'b1;
        end else if (p == 6'd1) begin
          l.drv = 1'b0;
          l.scl = 1'b1;
        end else if (p == 6'd4) begin
          l.scl = 1'b0;
        end
      end
    endcase
    return l;
  endfunction

  // phase length clamped to the counter range, zero acts as one
  assign pt_ext = LW'(phase_ticks);

  always_comb begin
    len_w = (pt_ext > CMAX) ? CMAX : pt_ext;
    len   = COUNT_WIDTH'(len_w);
    if (len == '0) begin
      len = COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    act_nxt   = act_r;
    ph_nxt    = ph_r;
    tick_nxt  = tick_r;
    sh_nxt    = sh_r;
    ack_nxt   = ack_r;
    rd_nxt    = rd_r;
    ln_nxt    = ln_r;
    done      = 1'b0;
    nx        = 6'd0;
    stop_poll = 1'b0;

    if (act_nxt == CMD_NONE && item.cmd != CMD_NONE) begin
      act_nxt  = item.cmd;
      ph_nxt   = 6'd0;
      tick_nxt = '0;
      if (item.cmd == CMD_WRITE) begin
        sh_nxt = item.data_byte;
      end
      if (item.cmd == CMD_READ) begin
        sh_nxt = 8'd0;
      end
      ln_nxt = enter_phase(act_nxt, 6'd0, sh_nxt, ln_nxt);
    end

    if (act_nxt != CMD_NONE) begin
      if (tick_nxt < len) begin
        tick_nxt = tick_nxt + COUNT_WIDTH'(1);
      end
      if (tick_nxt >= len) begin
        nx = ph_nxt + 6'd1;
        if (act_nxt == CMD_READ && mod6(ph_nxt) == 6'd1) begin
          sh_nxt = {sh_nxt[6:0], item.sda_in};
        end
        if ((act_nxt == CMD_CHECK_ACK || act_nxt == CMD_NACK_WAIT) &&
            ph_nxt >= 6'd1 && ph_nxt <= 6'd3) begin
          stop_poll = (act_nxt == CMD_CHECK_ACK) ? !item.sda_in : item.sda_in;
          if (stop_poll || ph_nxt == 6'd3) begin
            if (act_nxt == CMD_CHECK_ACK) begin
              ack_nxt = item.sda_in;
            end
            nx = 6'd4;
          end
        end
        tick_nxt = '0;
        if (nx >= phase_total(act_nxt)) begin
          if (act_nxt == CMD_READ) begin
            rd_nxt = sh_nxt;
          end else if (act_nxt != CMD_CHECK_ACK && act_nxt != CMD_NACK_WAIT) begin
            ln_nxt.drv = 1'b0;
          end
          act_nxt = CMD_NONE;
          ph_nxt  = 6'd0;
          done    = 1'b1;
        end else begin
          ph_nxt = nx;
          ln_nxt = enter_phase(act_nxt, ph_nxt, sh_nxt, ln_nxt);
        end
      end
    end
  end

  always_comb begin
    res.scl_level = ln_nxt.scl;
    res.sda_drive = ln_nxt.drv;
    res.sda_level = ln_nxt.lvl;
    res.busy_res  = (act_nxt != CMD_NONE);
    res.done_res  = done;
    res.read_byte = rd_nxt;
    res.ack_bit   = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= CMD_NONE;
      ph_r   <= 6'd0;
      tick_r <= '0;
      sh_r   <= 8'd0;
      ack_r  <= 1'b1;
      rd_r   <= 8'd0;
      ln_r   <= '{scl: 1'b0, drv: 1'b0, lvl: 1'b1};
    end else if (adv) begin
      act_r  <= act_nxt;
      ph_r   <= ph_nxt;
      tick_r <= tick_nxt;
      sh_r   <= sh_nxt;
      ack_r  <= ack_nxt;
      rd_r   <= rd_nxt;
      ln_r   <= ln_nxt;
    end
  end

  `I2CMS_ASSERT(a_phase_in_range, (act_r != CMD_NONE) |-> (ph_r < phase_total(act_r)), "phase index beyond sequence")
  `I2CMS_ASSERT(a_idle_cleared, (act_r == CMD_NONE) |-> (ph_r == 6'd0 && tick_r == '0), "idle with stale phase or tick")
  `I2CMS_ASSERT(a_done_ends_busy, (adv && res.done_res) |=> (act_r == CMD_NONE), "done without returning idle")
  `I2CMS_ASSERT(a_read_releases, (act_r == CMD_READ) |-> (!ln_r.drv && ln_r.lvl), "sda driven during read")

endmodule

/* design/i2cms_out_reg.sv */
// result register of the i2c master bit sequencer
// depends on i2cms_pkg
module i2cms_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  i2cms_pkg::out_item_t res,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cms_pkg::out_item_t out_item
);
  import i2cms_pkg::*;

  logic      valid_r;
  out_item_t res_r;

  assign adv       = item_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_item  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

endmodule

/* design/i2c_master_bit_sequencer.sv */
// Each request is one clock tick of the I2C line sequencer and yields exactly one
// result, in order. A request is registered on entry, the sequencer state is
// updated in a single pass, and the result is registered on exit, with one request
// per cycle sustained while out_ready stays high. A start, stop or command byte spans
// a number of ticks set by phase_ticks (cfg_wdata, reset 100); commands that arrive
// while a sequence runs are dropped.
// top level of the i2c master bit sequencer
// depends on i2cms_pkg, i2cms_in_reg, i2cms_core and i2cms_out_reg
module i2c_master_bit_sequencer #(
  parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  i2cms_pkg::in_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output i2cms_pkg::out_item_t       out_item,
  input  logic                      cfg_we,
  input  logic [i2cms_pkg::PT_W-1:0] cfg_wdata
);
  import i2cms_pkg::*;

  logic [PT_W-1:0] phase_ticks_r;
  logic            item_valid;
  in_item_t        item;
  out_item_t       res;
  logic            adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  i2cms_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cms_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .item        (item),
    .adv         (adv),
    .res         (res)
  );

  i2cms_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

/* tb/tb_i2c_master_bit_sequencer.sv */
`timescale 1ns / 1ps
// testbench for the i2c master bit sequencer: a directed table of line ticks,
// then random ticks under several phase lengths, checked against an in-bench model
// depends on i2cms_pkg and i2c_master_bit_sequencer
module tb_i2c_master_bit_sequencer;
  import i2cms_pkg::*;

  localparam out_item_t RESET_VIEW = '{scl_level: 1'b0, sda_drive: 1'b0, sda_level: 1'b1,
    busy_res: 1'b0, done_res: 1'b0, read_byte: 8'h00, ack_bit: 1'b1};

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data;
    logic       sda;
    int         reps;
    bit         typed;
  } tick_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_item;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_item;
  logic            cfg_we;
  logic [PT_W-1:0] cfg_wdata;

  logic [PT_W-1:0] phase_len_cfg;
  cmd_t            run_cmd;
  logic [5:0]      run_phase;
  logic [15:0]     run_ticks;
  logic [7:0]      shifter;
  logic [7:0]      last_read;
  logic            last_ack;
  line_t           lines;

  out_item_t pending_line_states[$];
  tick_row_t dir_rows[$];
  out_item_t line_want;
  int        errors;
  bit        calm;
  int        ready_hold;
  logic      sda_now;

  i2c_master_bit_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int phase_count(cmd_t c);
    case (c)
      CMD_START: return 4;
      CMD_STOP:  return 3;
      CMD_WRITE: return 24;
      CMD_READ:  return 48;
      CMD_MACK:  return 4;
      default:   return 5;
    endcase
  endfunction

  function automatic void enter_phase(cmd_t c, int ph);
    case (c)
      CMD_START: begin
        if (ph == 0) begin
          lines.drv = 1'b1;
          lines.lvl = 1'b1;
        end else if (ph == 1) lines.scl = 1'b1;
        else if (ph == 2) lines.lvl = 1'b0;
        else lines.scl = 1'b0;
      end
      CMD_STOP: begin
        if (ph == 0) begin
          lines.drv = 1'b1;
          lines.lvl = 1'b0;
        end else if (ph == 1) lines.scl = 1'b1;
        else lines.lvl = 1'b1;
      end
      CMD_WRITE: begin
        if (ph % 3 == 0) begin
          lines.drv = 1'b1;
          lines.lvl = shifter[7 - (ph / 3) % 8];
        end else if (ph % 3 == 1) lines.scl = 1'b1;
        else lines.scl = 1'b0;
      end
      CMD_READ: begin
        if (ph == 0) begin
          lines.drv = 1'b0;
          lines.lvl = 1'b1;
        end
        if (ph % 6 == 0) lines.scl = 1'b1;
        else if (ph % 6 == 4) lines.scl = 1'b0;
      end
      CMD_MACK: begin
        if (ph == 0) begin
          lines.drv = 1'b1;
          lines.lvl = 1'b0;
        end else if (ph == 1) lines.scl = 1'b1;
        else if (ph == 3) lines.scl = 1'b0;
      end
      default: begin
        if (ph == 0) begin
          lines.drv = 1'b1;
          lines.lvl = 1'b1;
        end else if (ph == 1) begin
          lines.drv = 1'b0;
          lines.scl = 1'b1;
        end else if (ph == 4) lines.scl = 1'b0;
      end
    endcase
  endfunction

  // returns the next phase; a poll phase may jump straight to the scl low phase
  function automatic int leave_phase(cmd_t c, int ph, logic sda);
    bit poll_over;
    if (c == CMD_READ && ph % 6 == 1) shifter = {shifter[6:0], sda};
    if ((c == CMD_CHECK_ACK || c == CMD_NACK_WAIT) && ph >= 1 && ph <= 3) begin
      poll_over = (c == CMD_CHECK_ACK) ? (sda == 1'b0) : (sda == 1'b1);
      if (poll_over || ph == 3) begin
        if (c == CMD_CHECK_ACK) last_ack = sda;
        return 4;
      end
    end
    return ph + 1;
  endfunction

  function automatic out_item_t predict_line_tick(in_item_t it);
    out_item_t r;
    int        phase_len;
    int        nx;
    cmd_t      c;
    logic      done;
    c = cmd_t'(it.cmd);
    done = 1'b0;
    phase_len = (phase_len_cfg == '0) ? 1 : int'(phase_len_cfg);
    if (run_cmd == CMD_NONE && c != CMD_NONE) begin
      run_cmd = c;
      run_phase = '0;
      run_ticks = '0;
      if (c == CMD_WRITE) shifter = it.data_byte;
      if (c == CMD_READ) shifter = '0;
      enter_phase(c, 0);
    end
    if (run_cmd != CMD_NONE) begin
      if (run_ticks < phase_len) run_ticks++;
      if (run_ticks >= phase_len) begin
        nx = leave_phase(run_cmd, int'(run_phase), it.sda_in);
        run_ticks = '0;
        if (nx >= phase_count(run_cmd)) begin
          if (run_cmd == CMD_READ) last_read = shifter;
          else if (run_cmd != CMD_CHECK_ACK && run_cmd != CMD_NACK_WAIT) lines.drv = 1'b0;
          run_cmd = CMD_NONE;
          run_phase = '0;
          done = 1'b1;
        end else begin
          run_phase = 6'(nx);
          enter_phase(run_cmd, nx);
        end
      end
    end
    r.scl_level = lines.scl;
    r.sda_drive = lines.drv;
    r.sda_level = lines.lvl;
    r.busy_res  = (run_cmd != CMD_NONE);
    r.done_res  = done;
    r.read_byte = last_read;
    r.ack_bit   = last_ack;
    return r;
  endfunction

  function automatic in_item_t random_tick();
    in_item_t it;
    if ($urandom_range(0, 3) == 0) sda_now = ~sda_now;
    it.sda_in = sda_now;
    it.data_byte = 8'($urandom_range(0, 255));
    it.cmd = CMD_NONE;
    // mostly issue a command when idle, with some ignored noise while busy
    if (run_cmd == CMD_NONE) begin
      if ($urandom_range(0, 9) < 8) it.cmd = 3'($urandom_range(1, 7));
    end else if ($urandom_range(0, 9) == 0) begin
      it.cmd = 3'($urandom_range(1, 7));
    end
    return it;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  task automatic send_tick(in_item_t it, bit typed);
    out_item_t seen;
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    seen = predict_line_tick(it);
    pending_line_states.push_back(typed ? RESET_VIEW : seen);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_line_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_phase_len(logic [PT_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    phase_len_cfg = v;
  endtask

  task automatic add_row(cmd_t c, logic [7:0] d, logic s, int n, bit typed);
    tick_row_t row;
    row.cmd = c;
    row.data = d;
    row.sda = s;
    row.reps = n;
    row.typed = typed;
    dir_rows.push_back(row);
  endtask

  initial begin
    ready_hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) out_ready <= 1'b1;
      else if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_line_states.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        line_want = pending_line_states.pop_front();
        compare_field("scl_level", 8'(line_want.scl_level), 8'(out_item.scl_level));
        compare_field("sda_drive", 8'(line_want.sda_drive), 8'(out_item.sda_drive));
        compare_field("sda_level", 8'(line_want.sda_level), 8'(out_item.sda_level));
        compare_field("busy_res", 8'(line_want.busy_res), 8'(out_item.busy_res));
        compare_field("done_res", 8'(line_want.done_res), 8'(out_item.done_res));
        compare_field("read_byte", line_want.read_byte, out_item.read_byte);
        compare_field("ack_bit", 8'(line_want.ack_bit), 8'(out_item.ack_bit));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int       phase_lens[6];
    int       counts[6];
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    calm = 1'b0;
    sda_now = 1'b1;
    phase_len_cfg = PHASE_TICKS_RST;
    run_cmd = CMD_NONE;
    run_phase = '0;
    run_ticks = '0;
    shifter = '0;
    last_read = '0;
    last_ack = 1'b1;
    lines.scl = 1'b0;
    lines.drv = 1'b0;
    lines.lvl = 1'b1;
    phase_lens = '{2, 65535, 1, 3, 4, 1};
    counts = '{120, 40, 120, 120, 120, 120};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero length behaves as one tick per phase
    write_phase_len('0);

    add_row(CMD_NONE, 8'h00, 1'b1, 1, 1'b1);
    add_row(CMD_START, 8'h00, 1'b1, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b1, 4, 1'b0);
    add_row(CMD_WRITE, 8'hFF, 1'b1, 1, 1'b0);
    add_row(CMD_NONE, 8'hFF, 1'b1, 23, 1'b0);
    add_row(CMD_WRITE, 8'h00, 1'b0, 1, 1'b0);
    // stop while busy, then read on the finishing tick: both dropped
    add_row(CMD_STOP, 8'h00, 1'b0, 3, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b0, 19, 1'b0);
    add_row(CMD_READ, 8'h00, 1'b0, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b0, 2, 1'b0);
    add_row(CMD_READ, 8'hA5, 1'b1, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b1, 47, 1'b0);
    add_row(CMD_READ, 8'h00, 1'b0, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b0, 48, 1'b0);
    add_row(CMD_MACK, 8'h00, 1'b0, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b0, 4, 1'b0);
    add_row(CMD_CHECK_ACK, 8'h00, 1'b1, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b0, 5, 1'b0);
    add_row(CMD_CHECK_ACK, 8'h00, 1'b1, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b1, 5, 1'b0);
    add_row(CMD_NACK_WAIT, 8'h00, 1'b0, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b1, 5, 1'b0);
    add_row(CMD_NACK_WAIT, 8'h00, 1'b0, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b0, 5, 1'b0);
    add_row(CMD_STOP, 8'hFF, 1'b1, 1, 1'b0);
    add_row(CMD_NONE, 8'h00, 1'b1, 3, 1'b0);

    foreach (dir_rows[i]) begin
      it.cmd = dir_rows[i].cmd;
      it.data_byte = dir_rows[i].data;
      it.sda_in = dir_rows[i].sda;
      repeat (dir_rows[i].reps) send_tick(it, dir_rows[i].typed);
    end

    // the longest phase length only runs briefly; the next setting cuts it short
    foreach (phase_lens[p]) begin
      drain_requests();
      write_phase_len(PT_W'(phase_lens[p]));
      calm = (p == 5);
      repeat (counts[p]) send_tick(random_tick(), 1'b0);
    end

    drain_requests();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
